### src/mdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared constants and types for the minimum-distance symbol demapper.
// ----------------------------------------------------------------------------
package mdd_pkg;

  // parameter defaults
  localparam int MAX_POINTS_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_BITS_DEF    = 12;

  // fixed field widths
  localparam int INDEX_W = 12;
  localparam int LABEL_W = 12;
  localparam int PTS_W   = 13;
  localparam int BPS_W   = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register map (word index)
  localparam logic [1:0] REG_POINTS = 2'd0;
  localparam logic [1:0] REG_BPS    = 2'd1;
  localparam logic [1:0] REG_MSB    = 2'd2;
  localparam logic [1:0] REG_LABELS = 2'd3;

  // register reset values
  localparam logic [PTS_W-1:0] POINTS_RST = PTS_W'(4);
  localparam logic [BPS_W-1:0] BPS_RST    = BPS_W'(2);

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DEMAP = 1'b1;

  typedef struct packed {
    logic [PTS_W-1:0] points_in_use;
    logic [BPS_W-1:0] bits_per_symbol;
    logic             high_bit_first;
    logic             use_labels;
  } cfg_t;

  // control that travels with each table read through the distance unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_ctl_t;

endpackage

### src/mdd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_if
// Valid/ready channel interfaces for demapper commands and result bits.
// ----------------------------------------------------------------------------
interface mdd_in_if #(
  parameter int SAMPLE_BITS = mdd_pkg::SAMPLE_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [mdd_pkg::INDEX_W-1:0]       entry_index;
  logic signed [SAMPLE_BITS-1:0]     in_i;
  logic signed [SAMPLE_BITS-1:0]     in_q;
  logic [mdd_pkg::LABEL_W-1:0]       entry_label;

  modport source (output valid, cmd, entry_index, in_i, in_q, entry_label, input ready);
  modport sink   (input valid, cmd, entry_index, in_i, in_q, entry_label, output ready);
endinterface

interface mdd_out_if #(
  parameter int SAMPLE_BITS = mdd_pkg::SAMPLE_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              bit_res;
  logic signed [SAMPLE_BITS-1:0]     near_i;
  logic signed [SAMPLE_BITS-1:0]     near_q;
  logic [mdd_pkg::INDEX_W-1:0]       near_index;
  logic                              last_bit;

  modport source (output valid, bit_res, near_i, near_q, near_index, last_bit, input ready);
  modport sink   (input valid, bit_res, near_i, near_q, near_index, last_bit, output ready);
endinterface

### src/mdd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/mdd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_cfg_regs
// APB register file: points in use, bits per symbol, bit order, label use.
// ----------------------------------------------------------------------------
module mdd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mdd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mdd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mdd_pkg::cfg_t                 cfg
);

  mdd_pkg::cfg_t regs;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.points_in_use   <= mdd_pkg::POINTS_RST;
      regs.bits_per_symbol <= mdd_pkg::BPS_RST;
      regs.high_bit_first  <= 1'b0;
      regs.use_labels      <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        mdd_pkg::REG_POINTS: regs.points_in_use   <= pwdata[mdd_pkg::PTS_W-1:0];
        mdd_pkg::REG_BPS:    regs.bits_per_symbol <= pwdata[mdd_pkg::BPS_W-1:0];
        mdd_pkg::REG_MSB:    regs.high_bit_first  <= pwdata[0];
        mdd_pkg::REG_LABELS: regs.use_labels      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mdd_pkg::REG_POINTS: prdata = mdd_pkg::PDATA_W'(regs.points_in_use);
      mdd_pkg::REG_BPS:    prdata = mdd_pkg::PDATA_W'(regs.bits_per_symbol);
      mdd_pkg::REG_MSB:    prdata = mdd_pkg::PDATA_W'(regs.high_bit_first);
      mdd_pkg::REG_LABELS: prdata = mdd_pkg::PDATA_W'(regs.use_labels);
      default:             prdata = '0;
    endcase
  end

endmodule

### src/mdd_dist_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_dist_unit
// Pipelined squared-distance unit with running minimum, one entry per cycle.
// ----------------------------------------------------------------------------
module mdd_dist_unit #(
  parameter int SAMPLE_BITS = mdd_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mdd_pkg::scan_ctl_t            issue_ctl,
  input  logic [IDX_W-1:0]              issue_idx,
  input  logic signed [SAMPLE_BITS-1:0] xi,
  input  logic signed [SAMPLE_BITS-1:0] xq,
  input  logic [SAMPLE_BITS-1:0]        pt_i,
  input  logic [SAMPLE_BITS-1:0]        pt_q,
  input  logic [mdd_pkg::LABEL_W-1:0]   pt_label,
  output logic                          done,
  output logic [IDX_W-1:0]              best_idx,
  output logic [SAMPLE_BITS-1:0]        best_i,
  output logic [SAMPLE_BITS-1:0]        best_q,
  output logic [mdd_pkg::LABEL_W-1:0]   best_label
);

  localparam int SB  = SAMPLE_BITS;
  localparam int SQ_W = 2 * SB;
  localparam int D_W  = 2 * SB + 1;

  // stage a: lines up with the RAM read data
  mdd_pkg::scan_ctl_t ctl_a, ctl_b, ctl_c, ctl_d;
  logic [IDX_W-1:0]   idx_a, idx_b, idx_c, idx_d;

  logic signed [SB:0] diff_i, diff_q;
  logic [SB-1:0]      abs_i, abs_q;

  logic [SB-1:0]               ai_b, aq_b, pi_b, pq_b, pi_c, pq_c, pi_d, pq_d;
  logic [mdd_pkg::LABEL_W-1:0] lab_b, lab_c, lab_d;
  logic [SQ_W-1:0]             sqi_c, sqq_c;
  logic [D_W-1:0]              sum_d, best_dist;
  logic                        take;

  // |d| never exceeds 2^SB - 1, so it fits SB bits
  assign diff_i = $signed({xi[SB-1], xi}) - $signed({pt_i[SB-1], pt_i});
  assign diff_q = $signed({xq[SB-1], xq}) - $signed({pt_q[SB-1], pt_q});
  assign abs_i  = diff_i[SB] ? SB'(-diff_i) : diff_i[SB-1:0];
  assign abs_q  = diff_q[SB] ? SB'(-diff_q) : diff_q[SB-1:0];

  // strict less keeps the lowest index on a tie
  assign take = ctl_d.vld & (ctl_d.first | (sum_d < best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_c <= '0;
      ctl_d <= '0;
      done  <= 1'b0;
    end else begin
      ctl_a <= issue_ctl;
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
      ctl_d <= ctl_c;
      done  <= ctl_d.vld & ctl_d.last;
    end
  end

  always_ff @(posedge clk) begin
    idx_a <= issue_idx;
    // stage b: absolute differences
    idx_b <= idx_a;
    ai_b  <= abs_i;
    aq_b  <= abs_q;
    pi_b  <= pt_i;
    pq_b  <= pt_q;
    lab_b <= pt_label;
    // stage c: squares
    idx_c <= idx_b;
    sqi_c <= SQ_W'(ai_b) * SQ_W'(ai_b);
    sqq_c <= SQ_W'(aq_b) * SQ_W'(aq_b);
    pi_c  <= pi_b;
    pq_c  <= pq_b;
    lab_c <= lab_b;
    // stage d: sum
    idx_d <= idx_c;
    sum_d <= D_W'(sqi_c) + D_W'(sqq_c);
    pi_d  <= pi_c;
    pq_d  <= pq_c;
    lab_d <= lab_c;
    // running minimum
    if (take) begin
      best_dist  <= sum_d;
      best_idx   <= idx_d;
      best_i     <= pi_d;
      best_q     <= pq_d;
      best_label <= lab_d;
    end
  end

endmodule

### src/min_distance_symbol_demapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_distance_symbol_demapper_top
// Hard-decision demapper: nearest constellation entry by squared distance.
// ----------------------------------------------------------------------------
// Commands arrive on din. A load (cmd 0) writes one table entry (point and
// label); indices at or above MAX_POINTS are dropped. A demap (cmd 1) scans
// entries 0 .. points_in_use-1 (clamped into 1 .. MAX_POINTS) through one
// pipelined distance unit, one table read per cycle from the table RAM,
// keeping the lowest index on a tie. The symbol (index, or stored label)
// then leaves on dout as bits_per_symbol transfers (clamped into 1 ..
// MAX_BITS), one bit each, with the nearest point, its index and a last-bit
// mark. A demap's bits leave one per cycle while dout is ready; din is not
// ready from demap accept until the last bit is loaded into the output
// register. dout is registered, so a new command can be taken while the
// final bit still waits; a stalled receiver holds the current bit and pauses
// emission. Configuration is to be written over APB only while idle; the
// block leaves this to the user. Reset returns the registers to 4 points, 2
// bits, LSB first, index output; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module min_distance_symbol_demapper_top #(
  parameter int MAX_POINTS  = mdd_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = mdd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BITS    = mdd_pkg::MAX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdd_pkg::PADDR_W-1:0] paddr,
  input  logic [mdd_pkg::PDATA_W-1:0] pwdata,
  output logic [mdd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  mdd_in_if.sink                      din,
  mdd_out_if.source                   dout
);

  localparam int SB    = SAMPLE_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int BC_W  = $clog2(MAX_BITS + 1);
  localparam int LW    = mdd_pkg::LABEL_W;
  localparam int RAM_W = 2 * SB + LW;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT, ST_EMIT} state_t;

  state_t              state;
  mdd_pkg::cfg_t       cfg;
  mdd_pkg::scan_ctl_t  issue_ctl;

  logic [CNT_W-1:0]    k, n_pts, n_pts_next;
  logic [BC_W-1:0]     bit_cnt, n_bits, n_bits_next, pos;
  logic signed [SB-1:0] xi, xq;

  logic                in_fire, ram_we;
  logic [RAM_W-1:0]    rdata;
  logic                done;
  logic [IDX_W-1:0]    best_idx;
  logic [SB-1:0]       best_i, best_q;
  logic [LW-1:0]       best_label, sym, sym_shift;
  logic                emit_load, emit_last;

  logic                out_vld, out_bit, out_last;
  logic [SB-1:0]       out_i, out_q;
  logic [mdd_pkg::INDEX_W-1:0] out_idx;

  mdd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign din.ready = (state == ST_IDLE);
  assign in_fire   = din.valid & din.ready;
  assign ram_we    = in_fire & (din.cmd == mdd_pkg::CMD_LOAD) &
                     (32'(din.entry_index) < MAX_POINTS);

  mdd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (din.entry_index[IDX_W-1:0]),
    .wdata ({din.entry_label, din.in_q, din.in_i}),
    .re    (issue_ctl.vld),
    .raddr (k[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign issue_ctl.vld   = (state == ST_SCAN);
  assign issue_ctl.first = (k == '0);
  assign issue_ctl.last  = (k == n_pts - CNT_W'(1));

  mdd_dist_unit #(
    .SAMPLE_BITS (SB),
    .IDX_W       (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .issue_ctl  (issue_ctl),
    .issue_idx  (k[IDX_W-1:0]),
    .xi         (xi),
    .xq         (xq),
    .pt_i       (rdata[SB-1:0]),
    .pt_q       (rdata[2*SB-1:SB]),
    .pt_label   (rdata[RAM_W-1:2*SB]),
    .done       (done),
    .best_idx   (best_idx),
    .best_i     (best_i),
    .best_q     (best_q),
    .best_label (best_label)
  );

  // out-of-range counts are clamped into 1 .. MAX
  always_comb begin
    if (cfg.points_in_use == '0) begin
      n_pts_next = CNT_W'(1);
    end else if (32'(cfg.points_in_use) > MAX_POINTS) begin
      n_pts_next = CNT_W'(MAX_POINTS);
    end else begin
      n_pts_next = CNT_W'(cfg.points_in_use);
    end
    if (cfg.bits_per_symbol == '0) begin
      n_bits_next = BC_W'(1);
    end else if (32'(cfg.bits_per_symbol) > MAX_BITS) begin
      n_bits_next = BC_W'(MAX_BITS);
    end else begin
      n_bits_next = BC_W'(cfg.bits_per_symbol);
    end
  end

  assign sym       = cfg.use_labels ? best_label : LW'(best_idx);
  assign pos       = cfg.high_bit_first ? (n_bits - BC_W'(1) - bit_cnt) : bit_cnt;
  assign sym_shift = sym >> pos;
  assign emit_load = (state == ST_EMIT) & (~out_vld | dout.ready);
  assign emit_last = (bit_cnt == n_bits - BC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      out_vld <= 1'b0;
      k       <= '0;
      bit_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && din.cmd == mdd_pkg::CMD_DEMAP) begin
            xi     <= din.in_i;
            xq     <= din.in_q;
            n_pts  <= n_pts_next;
            n_bits <= n_bits_next;
            k      <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          k <= k + CNT_W'(1);
          if (issue_ctl.last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (done) begin
            bit_cnt <= '0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            bit_cnt <= bit_cnt + BC_W'(1);
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (emit_load) begin
        out_vld  <= 1'b1;
        out_bit  <= sym_shift[0];
        out_i    <= best_i;
        out_q    <= best_q;
        out_idx  <= mdd_pkg::INDEX_W'(best_idx);
        out_last <= emit_last;
      end else if (dout.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign dout.valid      = out_vld;
  assign dout.bit_res    = out_bit;
  assign dout.near_i     = out_i;
  assign dout.near_q     = out_q;
  assign dout.near_index = out_idx;
  assign dout.last_bit   = out_last;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the minimum-distance symbol demapper.
// ----------------------------------------------------------------------------
// Commands (table loads and demaps) go in over the valid/ready input channel
// from a queue. Each accepted command updates a behavioural copy of the
// constellation table, or searches it for the nearest entry and queues the
// expected output bits. Output transfers are checked in order against that
// queue. Configuration goes over APB between phases, with both channels
// quiet. A directed opening covers the field extremes, ties and register
// corner values, random phases follow, the last of them scanning up to
// every loaded entry. Demaps only ever scan entries that were loaded.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_ENTRIES       = mdd_pkg::MAX_POINTS_DEF;
  localparam int WATCHDOG_CYCLES = 20000;

  typedef struct {
    logic                        cmd;
    logic [mdd_pkg::INDEX_W-1:0] entry_index;
    logic signed [15:0]          in_i;
    logic signed [15:0]          in_q;
    logic [mdd_pkg::LABEL_W-1:0] entry_label;
  } demap_cmd_t;

  typedef struct packed {
    logic                        bit_res;
    logic signed [15:0]          near_i;
    logic signed [15:0]          near_q;
    logic [mdd_pkg::INDEX_W-1:0] near_index;
    logic                        last_bit;
  } demap_bit_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mdd_pkg::PADDR_W-1:0] paddr;
  logic [mdd_pkg::PDATA_W-1:0] pwdata;
  logic [mdd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  mdd_in_if  din_if ();
  mdd_out_if dout_if ();

  min_distance_symbol_demapper_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din     (din_if),
    .dout    (dout_if)
  );

  // predicted block state
  logic signed [15:0]          tbl_i [N_ENTRIES];
  logic signed [15:0]          tbl_q [N_ENTRIES];
  logic [mdd_pkg::LABEL_W-1:0] tbl_label [N_ENTRIES];
  mdd_pkg::cfg_t               dm_cfg;

  // what the stimulus side knows has been loaded
  logic signed [15:0] gen_i [N_ENTRIES];
  logic signed [15:0] gen_q [N_ENTRIES];
  bit                 loaded [N_ENTRIES];
  int                 filled;

  demap_cmd_t pending_cmds[$];
  demap_bit_t expected_bits[$];
  demap_cmd_t cur_cmd;
  int         cmds_open;
  int         mismatches;
  int         idle_cycles;
  int         send_gap;
  int         recv_wait;
  bit         send_fast;
  bit         recv_fast;
  bit         in_fire;
  bit         out_fire;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // nearest-point search and bit emission for one accepted command
  task automatic demap_command(input demap_cmd_t c);
    int         n;
    int         nbits;
    int         best;
    int         pos;
    int         k;
    longint     di;
    longint     dq;
    longint     sq_dist;
    longint     best_dist;
    logic [11:0] sym;
    demap_bit_t r;
    if (c.cmd == mdd_pkg::CMD_LOAD) begin
      tbl_i[c.entry_index]     = c.in_i;
      tbl_q[c.entry_index]     = c.in_q;
      tbl_label[c.entry_index] = c.entry_label;
    end else begin
      n = dm_cfg.points_in_use;
      if (n == 0) n = 1;
      if (n > N_ENTRIES) n = N_ENTRIES;
      nbits = dm_cfg.bits_per_symbol;
      if (nbits == 0) nbits = 1;
      if (nbits > mdd_pkg::MAX_BITS_DEF) nbits = mdd_pkg::MAX_BITS_DEF;
      best      = 0;
      best_dist = 0;
      for (k = 0; k < n; k++) begin
        di      = longint'(c.in_i) - longint'(tbl_i[k]);
        dq      = longint'(c.in_q) - longint'(tbl_q[k]);
        sq_dist = di * di + dq * dq;
        // strict compare keeps the lowest index on a tie
        if (k == 0 || sq_dist < best_dist) begin
          best_dist = sq_dist;
          best      = k;
        end
      end
      sym = dm_cfg.use_labels ? tbl_label[best] : best[11:0];
      for (k = 0; k < nbits; k++) begin
        pos          = dm_cfg.high_bit_first ? (nbits - 1 - k) : k;
        r.bit_res    = sym[pos];
        r.near_i     = tbl_i[best];
        r.near_q     = tbl_q[best];
        r.near_index = best[11:0];
        r.last_bit   = (k == nbits - 1);
        expected_bits = {expected_bits, r};
      end
    end
  endtask

  // accept, predict and check at the rising edge
  always @(posedge clk) begin
    in_fire  = !rst && din_if.valid && din_if.ready;
    out_fire = !rst && dout_if.valid && dout_if.ready;
    if (in_fire) begin
      demap_command(cur_cmd);
      cmds_open--;
    end
    if (out_fire) begin
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected result, bit %0b i %0d q %0d index %0d last %0b", $time,
                 dout_if.bit_res, dout_if.near_i, dout_if.near_q, dout_if.near_index,
                 dout_if.last_bit);
        mismatches++;
      end else begin
        demap_bit_t e;
        e = expected_bits.pop_front();
        if (dout_if.bit_res !== e.bit_res || dout_if.near_i !== e.near_i ||
            dout_if.near_q !== e.near_q || dout_if.near_index !== e.near_index ||
            dout_if.last_bit !== e.last_bit) begin
          $display("%0t: mismatch, expected bit %0b i %0d q %0d index %0d last %0b", $time,
                   e.bit_res, e.near_i, e.near_q, e.near_index, e.last_bit);
          $display("%0t:           got bit %0b i %0d q %0d index %0d last %0b", $time,
                   dout_if.bit_res, dout_if.near_i, dout_if.near_q, dout_if.near_index,
                   dout_if.last_bit);
          mismatches++;
        end
      end
    end
    if (rst || in_fire || out_fire || psel) idle_cycles = 0;
    else idle_cycles++;
  end

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        din_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        din_if.cmd         <= cur_cmd.cmd;
        din_if.entry_index <= cur_cmd.entry_index;
        din_if.in_i        <= cur_cmd.in_i;
        din_if.in_q        <= cur_cmd.in_q;
        din_if.entry_label <= cur_cmd.entry_label;
        din_if.valid       <= 1'b1;
        send_gap = send_fast ? 0 : $urandom_range(0, 6);
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if (out_fire) recv_wait = recv_fast ? 0 : $urandom_range(0, 6);
      if (recv_wait > 0) begin
        recv_wait--;
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_load(input int idx, input logic signed [15:0] pi,
                            input logic signed [15:0] pq, input logic [11:0] lbl);
    demap_cmd_t c;
    c.cmd         = mdd_pkg::CMD_LOAD;
    c.entry_index = idx[mdd_pkg::INDEX_W-1:0];
    c.in_i        = pi;
    c.in_q        = pq;
    c.entry_label = lbl;
    gen_i[idx]    = pi;
    gen_q[idx]    = pq;
    loaded[idx]   = 1'b1;
    while (filled < N_ENTRIES && loaded[filled]) filled++;
    cmds_open++;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic queue_demap(input logic signed [15:0] si, input logic signed [15:0] sq);
    demap_cmd_t c;
    c.cmd         = mdd_pkg::CMD_DEMAP;
    c.entry_index = 12'($urandom);
    c.in_i        = si;
    c.in_q        = sq;
    c.entry_label = 12'($urandom);
    cmds_open++;
    pending_cmds = {pending_cmds, c};
  endtask

  // sender holds off until every command is taken and every bit has come
  task automatic drain_results();
    while (cmds_open > 0 || expected_bits.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      mdd_pkg::REG_POINTS: dm_cfg.points_in_use   = value[mdd_pkg::PTS_W-1:0];
      mdd_pkg::REG_BPS:    dm_cfg.bits_per_symbol = value[mdd_pkg::BPS_W-1:0];
      mdd_pkg::REG_MSB:    dm_cfg.high_bit_first  = value[0];
      default:             dm_cfg.use_labels      = value[0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input int max_pts);
    int pts;
    int mx;
    int k;
    int j;
    int idx;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    mx  = (max_pts < filled) ? max_pts : filled;
    // mostly short scans, now and then a long one
    pts = ($urandom_range(0, 3) == 0) ? $urandom_range(1, mx)
                                      : $urandom_range(1, (mx < 24) ? mx : 24);
    drain_results();
    cfg_write(mdd_pkg::REG_POINTS, pts);
    cfg_write(mdd_pkg::REG_BPS, $urandom_range(0, 15));
    cfg_write(mdd_pkg::REG_MSB, $urandom_range(0, 1));
    cfg_write(mdd_pkg::REG_LABELS, $urandom_range(0, 1));
    send_fast = ($urandom_range(0, 3) == 0);
    recv_fast = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_results();
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0, 1:    idx = $urandom_range(0, filled - 1);
          2:       idx = (filled < N_ENTRIES) ? filled : $urandom_range(0, N_ENTRIES - 1);
          default: idx = $urandom_range(0, N_ENTRIES - 1);
        endcase
        if ($urandom_range(0, 1)) begin
          // duplicate point gives ties
          j  = $urandom_range(0, filled - 1);
          si = gen_i[j];
          sq = gen_q[j];
        end else begin
          si = 16'($urandom);
          sq = 16'($urandom);
        end
        queue_load(idx, si, sq, 12'($urandom));
      end else begin
        j = $urandom_range(0, pts - 1);
        case ($urandom_range(0, 2))
          0: begin
            si = gen_i[j];
            sq = gen_q[j];
          end
          1: begin
            si = gen_i[j] + 16'($urandom_range(0, 64) - 32);
            sq = gen_q[j] + 16'($urandom_range(0, 64) - 32);
          end
          default: begin
            si = 16'($urandom);
            sq = 16'($urandom);
          end
        endcase
        queue_demap(si, sq);
      end
    end
  endtask

  initial begin
    int k;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    din_if.valid       = 1'b0;
    din_if.cmd         = mdd_pkg::CMD_LOAD;
    din_if.entry_index = '0;
    din_if.in_i        = '0;
    din_if.in_q        = '0;
    din_if.entry_label = '0;
    dout_if.ready      = 1'b0;
    dm_cfg.points_in_use   = mdd_pkg::POINTS_RST;
    dm_cfg.bits_per_symbol = mdd_pkg::BPS_RST;
    dm_cfg.high_bit_first  = 1'b0;
    dm_cfg.use_labels      = 1'b0;
    filled      = 0;
    cmds_open   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    send_gap    = 0;
    recv_wait   = 0;
    send_fast   = 1'b0;
    recv_fast   = 1'b0;
    for (k = 0; k < N_ENTRIES; k++) loaded[k] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners of the sample range, a duplicate of entry 1, two points
    // equally far from the origin
    queue_load(0, 16'sh7FFF, 16'sh7FFF, 12'hFFF);
    queue_load(1, -16'sh8000, -16'sh8000, 12'h000);
    queue_load(2, 16'sh7FFF, -16'sh8000, 12'hA5A);
    queue_load(3, -16'sh8000, 16'sh7FFF, 12'h5A5);
    queue_load(4, -16'sh8000, -16'sh8000, 12'h3C3);
    queue_load(5, 16'sd200, 16'sd0, 12'h800);
    queue_load(6, 16'sd0, 16'sd200, 12'h7FF);
    // registers still at reset values
    queue_demap(16'sh7FFF, 16'sh7FFF);
    queue_demap(-16'sh8000, 16'sh7FFF);
    queue_demap(16'sd0, 16'sd0);
    queue_demap(-16'sd1, -16'sd1);
    drain_results();
    cfg_write(mdd_pkg::REG_POINTS, 7);
    cfg_write(mdd_pkg::REG_BPS, 12);
    cfg_write(mdd_pkg::REG_MSB, 1);
    cfg_write(mdd_pkg::REG_LABELS, 1);
    queue_demap(-16'sh8000, -16'sh8000);
    queue_demap(16'sd0, 16'sd0);
    queue_demap(16'sd200, 16'sd0);
    drain_results();
    // zero points and zero bits both act as one
    cfg_write(mdd_pkg::REG_POINTS, 0);
    cfg_write(mdd_pkg::REG_BPS, 0);
    queue_demap(16'sd123, -16'sd456);

    for (k = 0; k < 5; k++) random_phase(20, 64);

    // scans may reach every loaded entry
    random_phase(20, N_ENTRIES);

    drain_results();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && expected_bits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
